@@ rtl/xpg_pkg.sv @@
// ----------------------------------------------------------------------------
// xpg_pkg: shared constants of the xoshiro128+ generator
// Widths, request kinds, reseed constants, reset state, draw step amounts.
// ----------------------------------------------------------------------------
package xpg_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 23;

  typedef logic [WORD_W-1:0] word_t;

  // Request kinds carried on the input tuser
  localparam logic REQ_DRAW   = 1'b0;
  localparam logic REQ_RESEED = 1'b1;

  // Multiplier of the reseed recurrence
  localparam word_t SEED_MULT = 32'd1812433253;

  // Shift that folds the high bits in before the multiply
  localparam int SEED_SHIFT = 30;

  // State after reset
  localparam word_t RESET_W0 = 32'd123456789;
  localparam word_t RESET_W1 = 32'd362436069;
  localparam word_t RESET_W2 = 32'd521288629;
  localparam word_t RESET_W3 = 32'd88675123;

  // Draw step amounts
  localparam int DRAW_SHIFT = 9;
  localparam int DRAW_ROT   = 11;

endpackage

@@ rtl/xpg_mul_unit.sv @@
// ----------------------------------------------------------------------------
// xpg_mul_unit: registered reseed multiplier
// Folds the previous word (w ^ (w >> 30)) and multiplies it by the seed
// constant, low 32 bits kept; the product is registered.
// ----------------------------------------------------------------------------
module xpg_mul_unit
  import xpg_pkg::*;
(
  input  logic  clk,
  input  word_t operand,
  output word_t product
);

  word_t folded;

  // Xor-shift fold ahead of the multiply
  assign folded = operand ^ (operand >> SEED_SHIFT);

  // Product modulo 2^32, registered
  always_ff @(posedge clk) begin
    product <= word_t'(folded * SEED_MULT);
  end

endmodule

@@ rtl/xoshiro128_plus_generator_top.sv @@
// ----------------------------------------------------------------------------
// xoshiro128_plus_generator_top: xoshiro128+ generator with reseed
// Draw and reseed requests in on one stream, draw results out on another.
// ----------------------------------------------------------------------------
// A draw request (s_tuser = 0) advances the state and captures the sum in the
// accept cycle; from the ST_DRAW step the result then moves to the output
// register once that register is free. While an earlier result still waits on
// m_tready, that ST_DRAW step holds until the output register frees, so one
// draw can be accepted while the previous result waits, and the input stalls
// behind it. A reseed request (s_tuser = 1) loads word 0 in the accept cycle;
// then words 1 to 3 each pass once through the single registered multiplier
// (a multiply step, then an add-and-write step). A reseed gives no result.
// The input is not ready while a request is at work.
module xoshiro128_plus_generator_top
  import xpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] seed_value
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // [31:0] raw_word, [54:32] frac_half_open,
                                 // [78:55] frac_open_zero, [79] zero pad
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DRAW = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_ADD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] idx;
  word_t      w0, w1, w2, w3;
  word_t      w0_next, w1_next, w2_next, w3_next;
  word_t      chain;
  word_t      pend;
  word_t      out_raw;
  word_t      product;
  word_t      seeded;
  word_t      t2, t3;
  logic       in_xact;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign in_xact  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Shared multiplier, fed from the word written last
  xpg_mul_unit u_mul (
    .clk     (clk),
    .operand (chain),
    .product (product)
  );

  assign seeded = product + {{(WORD_W-2){1'b0}}, idx};

  // Draw step of the state words
  always_comb begin
    t2      = w2 ^ w0;
    t3      = w3 ^ w1;
    w1_next = w1 ^ t2;
    w0_next = w0 ^ t3;
    w2_next = t2 ^ (w1 << DRAW_SHIFT);
    w3_next = {t3[WORD_W-DRAW_ROT-1:0], t3[WORD_W-1:WORD_W-DRAW_ROT]};
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xact) begin
          state_next = (s_tuser == REQ_RESEED) ? ST_MUL : ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        state_next = (idx == 2'd3) ? ST_IDLE : ST_MUL;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // State words and reseed chain
  always_ff @(posedge clk) begin
    if (rst) begin
      w0  <= RESET_W0;
      w1  <= RESET_W1;
      w2  <= RESET_W2;
      w3  <= RESET_W3;
      idx <= 2'd1;
    end else begin
      if (in_xact && (s_tuser == REQ_DRAW)) begin
        w0 <= w0_next;
        w1 <= w1_next;
        w2 <= w2_next;
        w3 <= w3_next;
      end else if (in_xact) begin
        w0  <= s_tdata;
        idx <= 2'd1;
      end else if (state == ST_ADD) begin
        case (idx)
          2'd1:    w1 <= seeded;
          2'd2:    w2 <= seeded;
          default: w3 <= seeded;
        endcase
        idx <= idx + 2'd1;
      end
    end
  end

  // Payload registers: chain operand and pending draw sum
  always_ff @(posedge clk) begin
    if (in_xact && (s_tuser == REQ_RESEED)) begin
      chain <= s_tdata;
    end else if (state == ST_ADD) begin
      chain <= seeded;
    end
    if (in_xact && (s_tuser == REQ_DRAW)) begin
      pend <= w0 + w3;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DRAW) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DRAW) && out_free) begin
      out_raw <= pend;
    end
  end

  assign m_tdata = {1'b0,
                    {1'b0, out_raw[FRAC_W-1:0]} + 24'd1,
                    out_raw[FRAC_W-1:0],
                    out_raw};

  // Checks
  a_reseed_starts: assert property (@(posedge clk) disable iff (rst)
    (in_xact && (s_tuser == REQ_RESEED)) |=> (state == ST_MUL))
    else $error("reseed did not enter multiply step");

  a_draw_starts: assert property (@(posedge clk) disable iff (rst)
    (in_xact && (s_tuser == REQ_DRAW)) |=> (state == ST_DRAW))
    else $error("draw did not enter transfer step");

  a_add_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |-> ($past(state) == ST_MUL))
    else $error("add step without a multiply before it");

  a_result_from_draw: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DRAW))
    else $error("result raised outside a draw");

  a_reseed_ends: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_ADD) && (idx == 2'd3)) |=> (state == ST_IDLE))
    else $error("reseed did not finish after word 3");

endmodule
